// ----- src/assert_macros.svh -----
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define XCBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define XCBT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/xcbt_pkg.sv -----
`default_nettype none
package xcbt_pkg;
  localparam int BLOCK_BYTES = 128;
  localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
  localparam int GRP_N = 4;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0, PH_FILL = 3'd1, PH_WACK = 3'd2,
    PH_WEOT = 3'd3, PH_DONE = 3'd4, PH_ABORT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0, OP_TICK = 2'd1, OP_RX = 2'd2, OP_PAYLOAD = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_LINE = 2'd0, K_REQ = 2'd1, K_STATUS = 2'd2, K_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    R_TOTAL = 3'd0, R_ACK_TO = 3'd1, R_EOT_TO = 3'd2, R_FILL_TO = 3'd3,
    R_RETRY = 3'd4, R_UNUSED5 = 3'd5, R_UNUSED6 = 3'd6, R_UNUSED7 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]              cnt;
    logic [GRP_N-1:0][1:0]   kind;
    logic [GRP_N-1:0][7:0]   bytes;
    logic [23:0]             blk;
    logic [2:0]              status;
  } grp_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- src/xcbt_if.sv -----
`default_nettype none
interface xcbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  modport source (output valid, operation, data_byte, input ready);
  modport sink (input valid, operation, data_byte, output ready);
endinterface

interface xcbt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [23:0] block_number;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, out_kind, out_byte, block_number, status, last,
                  input ready);
  modport sink (input valid, out_kind, out_byte, block_number, status, last,
                output ready);
endinterface
`default_nettype wire

// ----- src/xcbt_front.sv -----
`default_nettype none
module xcbt_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  take,
  input  wire [1:0]            operation,
  input  wire [7:0]            data_byte,
  input  wire                  cfg_we,
  input  wire [2:0]            cfg_index,
  input  wire [23:0]           cfg_data,
  output xcbt_pkg::grp_t       grp
);
  logic [23:0] total_r;
  logic [15:0] ack_to_r, eot_to_r, fill_to_r;
  logic [7:0]  retry_lim_r;

  xcbt_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  pkt_r, pkt_nxt;
  logic [23:0] blk_r, blk_nxt;
  logic [xcbt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  retry_r, retry_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] limit;
  logic        expired;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      ack_to_r <= 16'd60000;
      eot_to_r <= 16'd10000;
      fill_to_r <= 16'd60000;
      retry_lim_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (xcbt_pkg::reg_idx_t'(cfg_index))
        xcbt_pkg::R_TOTAL:   total_r <= cfg_data;
        xcbt_pkg::R_ACK_TO:  ack_to_r <= cfg_data[15:0];
        xcbt_pkg::R_EOT_TO:  eot_to_r <= cfg_data[15:0];
        xcbt_pkg::R_FILL_TO: fill_to_r <= cfg_data[15:0];
        xcbt_pkg::R_RETRY:   retry_lim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xcbt_pkg::PH_IDLE;
      pkt_r <= 8'd1;
      blk_r <= '0;
      cnt_r <= '0;
      crc_r <= '0;
      retry_r <= '0;
      tick_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      pkt_r <= pkt_nxt;
      blk_r <= blk_nxt;
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      retry_r <= retry_nxt;
      tick_r <= tick_nxt;
    end
  end

  always_comb begin
    case (phase_r)
      xcbt_pkg::PH_FILL: limit = fill_to_r;
      xcbt_pkg::PH_WACK: limit = ack_to_r;
      default:           limit = eot_to_r;
    endcase
    expired = tick_r >= limit;
  end

  always_comb begin
    logic do_req, do_eot, do_can, do_fail;
    logic [15:0] crc_new;
    do_req = 1'b0;
    do_eot = 1'b0;
    do_can = 1'b0;
    do_fail = 1'b0;
    crc_new = xcbt_pkg::crc16_byte(crc_r, data_byte);
    phase_nxt = phase_r;
    pkt_nxt = pkt_r;
    blk_nxt = blk_r;
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    retry_nxt = retry_r;
    tick_nxt = tick_r;
    grp.cnt = 3'd0;
    grp.kind = '0;
    grp.bytes = '0;

    case (xcbt_pkg::op_t'(operation))
      xcbt_pkg::OP_START: begin
        pkt_nxt = 8'd1;
        blk_nxt = '0;
        retry_nxt = '0;
        if (total_r == '0) do_eot = 1'b1;
        else do_req = 1'b1;
      end
      xcbt_pkg::OP_TICK: begin
        if (phase_r == xcbt_pkg::PH_FILL || phase_r == xcbt_pkg::PH_WACK ||
            phase_r == xcbt_pkg::PH_WEOT) begin
          if (!expired) tick_nxt = tick_r + 16'd1;
          else if (phase_r == xcbt_pkg::PH_WEOT) do_can = 1'b1;
          else do_fail = 1'b1;
        end
      end
      xcbt_pkg::OP_RX: begin
        if (phase_r == xcbt_pkg::PH_WACK) begin
          if (data_byte == xcbt_pkg::CH_ACK) begin
            blk_nxt = blk_r + 24'd1;
            pkt_nxt = pkt_r + 8'd1;
            retry_nxt = '0;
            if (blk_nxt >= total_r) do_eot = 1'b1;
            else do_req = 1'b1;
          end else if (data_byte == xcbt_pkg::CH_NAK) begin
            do_fail = 1'b1;
          end else if (data_byte == xcbt_pkg::CH_EOT) begin
            phase_nxt = xcbt_pkg::PH_DONE;
          end
        end else if (phase_r == xcbt_pkg::PH_WEOT) begin
          if (data_byte == xcbt_pkg::CH_ACK) phase_nxt = xcbt_pkg::PH_DONE;
          else if (data_byte == xcbt_pkg::CH_NAK) do_can = 1'b1;
        end
      end
      default: begin
        if (phase_r == xcbt_pkg::PH_FILL) begin
          crc_nxt = crc_new;
          cnt_nxt = cnt_r + 1'b1;
          grp.cnt = 3'd1;
          grp.kind[0] = xcbt_pkg::K_LINE;
          grp.bytes[0] = data_byte;
          if (cnt_nxt >= xcbt_pkg::CNT_W'(xcbt_pkg::BLOCK_BYTES)) begin
            grp.cnt = 3'd3;
            grp.kind[1] = xcbt_pkg::K_LINE;
            grp.bytes[1] = crc_new[15:8];
            grp.kind[2] = xcbt_pkg::K_LINE;
            grp.bytes[2] = crc_new[7:0];
            cnt_nxt = '0;
            tick_nxt = '0;
            phase_nxt = xcbt_pkg::PH_WACK;
          end
        end
      end
    endcase

    if (do_fail) begin
      if (retry_r > {1'b0, retry_lim_r}) begin
        do_can = 1'b1;
      end else begin
        retry_nxt = retry_r + 9'd1;
        do_req = 1'b1;
      end
    end

    if (do_req) begin
      cnt_nxt = '0;
      crc_nxt = '0;
      tick_nxt = '0;
      phase_nxt = xcbt_pkg::PH_FILL;
      grp.cnt = 3'd4;
      grp.kind[0] = xcbt_pkg::K_REQ;
      grp.bytes[0] = 8'h00;
      grp.kind[1] = xcbt_pkg::K_LINE;
      grp.bytes[1] = xcbt_pkg::CH_SOH;
      grp.kind[2] = xcbt_pkg::K_LINE;
      grp.bytes[2] = pkt_nxt;
      grp.kind[3] = xcbt_pkg::K_LINE;
      grp.bytes[3] = ~pkt_nxt;
    end
    if (do_eot) begin
      phase_nxt = xcbt_pkg::PH_WEOT;
      tick_nxt = '0;
      grp.cnt = 3'd1;
      grp.kind[0] = xcbt_pkg::K_LINE;
      grp.bytes[0] = xcbt_pkg::CH_EOT;
    end
    if (do_can) begin
      phase_nxt = xcbt_pkg::PH_ABORT;
      grp.cnt = 3'd1;
      grp.kind[0] = xcbt_pkg::K_LINE;
      grp.bytes[0] = xcbt_pkg::CH_CAN;
    end
    if (grp.cnt == 3'd0) begin
      grp.cnt = 3'd1;
      grp.kind[0] = xcbt_pkg::K_STATUS;
    end
    grp.blk = blk_nxt;
    grp.status = phase_nxt;
  end
endmodule
`default_nettype wire

// ----- src/xcbt_queue.sv -----
`default_nettype none
module xcbt_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire xcbt_pkg::grp_t  wr_grp,
  input  wire                  pop,
  output xcbt_pkg::grp_t       rd_grp,
  output logic                 not_empty,
  output logic                 full
);
  xcbt_pkg::grp_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rd_grp = mem_r[rp_r];
  assign not_empty = cnt_r != 2'd0;
  assign full = cnt_r == 2'd2;
endmodule
`default_nettype wire

// ----- src/xcbt_back.sv -----
`default_nettype none
module xcbt_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire xcbt_pkg::grp_t  head,
  input  wire                  head_valid,
  output logic                 pop,
  xcbt_out_if.source           out_if
);
  xcbt_pkg::grp_t cur_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       is_last, load;

  assign is_last = {1'b0, idx_r} == cur_r.cnt - 3'd1;
  assign load = !busy_r || (out_if.ready && is_last);
  assign pop = load && head_valid;

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      busy_r <= head_valid;
      idx_r <= '0;
    end else if (out_if.ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  assign out_if.valid = busy_r;
  assign out_if.out_kind = cur_r.kind[idx_r];
  assign out_if.out_byte = cur_r.bytes[idx_r];
  assign out_if.block_number = cur_r.blk;
  assign out_if.status = cur_r.status;
  assign out_if.last = is_last;
endmodule
`default_nettype wire

// ----- src/xmodem_crc_block_transmitter_unit.sv -----
`default_nettype none
// channel  dir  words                               handshake
// in_if    in   operation, data_byte                valid/ready
// out_if   out  out_kind, out_byte, block_number,   valid/ready
//               status, last
// cfg      in   cfg_we, cfg_index, cfg_data         write enable only
// One input word is taken per cycle while the two-entry group queue has room.
// Each input gives one to four output words, sent by the back end one per
// cycle while out_if.ready is high. Sustained rate is set by the output side
// and how many words each input makes. Synchronous active-low reset; no
// clearing pass. Output stalls back up through the queue to in_if.ready.
module xmodem_crc_block_transmitter_unit (
  input  wire         clk,
  input  wire         rst_n,
  xcbt_in_if.sink     in_if,
  xcbt_out_if.source  out_if,
  input  wire         cfg_we,
  input  wire [2:0]   cfg_index,
  input  wire [23:0]  cfg_data
);
  xcbt_pkg::grp_t fgrp, hgrp;
  logic take, pop, hvalid, full;

  assign in_if.ready = !full;
  assign take = in_if.valid && !full;

  xcbt_front u_front (
    .clk, .rst_n, .take,
    .operation(in_if.operation), .data_byte(in_if.data_byte),
    .cfg_we, .cfg_index, .cfg_data, .grp(fgrp)
  );

  xcbt_queue u_queue (
    .clk, .rst_n, .push(take), .wr_grp(fgrp), .pop,
    .rd_grp(hgrp), .not_empty(hvalid), .full
  );

  xcbt_back u_back (
    .clk, .rst_n, .head(hgrp), .head_valid(hvalid), .pop, .out_if
  );
endmodule
`default_nettype wire

// ----- src/xcbt_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module xcbt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_kind,
  input wire [7:0]  out_byte,
  input wire [2:0]  status,
  input wire        last
);
  `XCBT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_byte), "stall lost")
  `XCBT_ASSERT(a_req_fill, out_valid && out_kind == xcbt_pkg::K_REQ |-> status == xcbt_pkg::PH_FILL, "request outside fill")
  `XCBT_ASSERT(a_stat_last, out_valid && out_kind == xcbt_pkg::K_STATUS |-> last, "status word not last")
  `XCBT_ASSERT(a_kind, out_valid |-> out_kind != xcbt_pkg::K_NONE, "bad kind")
endmodule

bind xmodem_crc_block_transmitter_unit xcbt_checker u_chk (
  .clk, .rst_n, .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_kind(out_if.out_kind), .out_byte(out_if.out_byte),
  .status(out_if.status), .last(out_if.last)
);
`default_nettype wire
